### sv/nfu_pkg.sv
// shared types and constants for the nal unit fu-a fragmenter
// no dependencies, used by every module of the block
package nfu_pkg;

  localparam logic [15:0] MaxPayloadReset = 16'd1400;
  localparam logic [15:0] MinPayload      = 16'd3;
  localparam logic [15:0] FuHdrBytes      = 16'd2;
  localparam int unsigned MinUnitLen      = 5;
  localparam int unsigned StartCodeLen    = 3;

  localparam logic [7:0] NriMask  = 8'h60;
  localparam logic [7:0] TypeMask = 8'h1f;
  localparam logic [7:0] FuTypeA  = 8'd28;
  localparam logic [7:0] FuStart  = 8'h80;
  localparam logic [7:0] FuEnd    = 8'h40;

  // byte position within a unit, saturating once past the first data byte
  localparam logic [2:0] IdxHeader    = 3'd3;
  localparam logic [2:0] IdxFirstData = 3'd4;
  localparam logic [2:0] IdxBeyond    = 3'd5;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  // one payload byte, optionally preceded by an fu indicator and fu header
  typedef struct packed {
    logic       with_fu;
    logic [7:0] fu_ind;
    logic [7:0] fu_hdr;
    logic [7:0] data;
    logic       start;
    logic       fin;
    logic       marker;
  } cmd_t;

endpackage

### sv/nfu_front.sv
// front end: tracks the nal unit, strips the start code and decides fragmentation
// depends on nfu_pkg, feeds one request per payload byte into nfu_queue
module nfu_front #(
  parameter int LENGTH_WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  logic [7:0]         data_byte_i,
  input  logic               first_byte_i,
  input  logic [15:0]        nal_length_i,
  input  logic               access_unit_end_i,
  input  logic [15:0]        max_payload_i,
  output logic               push_o,
  output nfu_pkg::cmd_t      cmd_o
);

  localparam int CW = (LENGTH_WIDTH > 16) ? LENGTH_WIDTH : 16;
  localparam logic [CW-1:0] LenMask = CW'({LENGTH_WIDTH{1'b1}});

  logic [2:0]              idx_q, idx_d;
  logic [7:0]              hdr_q, hdr_d;
  logic                    frag_q, frag_d;
  logic [LENGTH_WIDTH-1:0] fill_q, fill_d;
  logic [LENGTH_WIDTH-1:0] left_q, left_d;
  logic                    drop_q, drop_d;
  logic                    au_q, au_d;

  logic [CW-1:0]           len_w, left_w, mp_w, fsz_w, fill_w;
  logic [15:0]             mp, fsz;
  logic [LENGTH_WIDTH-1:0] fill_inc;
  logic                    is_final, end_frag;

  always_comb begin
    len_w    = CW'(nal_length_i) & LenMask;
    mp       = (max_payload_i < nfu_pkg::MinPayload) ? nfu_pkg::MinPayload : max_payload_i;
    fsz      = mp - nfu_pkg::FuHdrBytes;
    mp_w     = CW'(mp);
    fsz_w    = CW'(fsz);
    left_w   = CW'(left_q);
    fill_inc = fill_q + LENGTH_WIDTH'(1);
    fill_w   = CW'(fill_inc);
    is_final = (left_q == LENGTH_WIDTH'(1));
    end_frag = is_final || (fill_w >= fsz_w);

    idx_d  = idx_q;
    hdr_d  = hdr_q;
    frag_d = frag_q;
    fill_d = fill_q;
    left_d = left_q;
    drop_d = drop_q;
    au_d   = au_q;
    push_o = 1'b0;
    cmd_o  = '0;

    if (take_i) begin
      if (first_byte_i) begin
        idx_d  = 3'd1;
        fill_d = '0;
        frag_d = 1'b0;
        hdr_d  = '0;
        au_d   = access_unit_end_i;
        if (len_w < CW'(nfu_pkg::MinUnitLen)) begin
          drop_d = 1'b1;
          left_d = '0;
        end else begin
          drop_d = 1'b0;
          left_d = LENGTH_WIDTH'(len_w - CW'(nfu_pkg::StartCodeLen));
        end
      end else if (!drop_q && (left_q != '0)) begin
        if (idx_q < nfu_pkg::IdxHeader) begin
          // still inside the start code
          idx_d = idx_q + 3'd1;
        end else begin
          left_d = left_q - LENGTH_WIDTH'(1);
          if (idx_q == nfu_pkg::IdxHeader) begin
            hdr_d = data_byte_i;
            idx_d = nfu_pkg::IdxFirstData;
            if (left_w > mp_w) begin
              // header consumed; nri goes to fu indicators, type to fu headers
              frag_d = 1'b1;
            end else begin
              frag_d       = 1'b0;
              push_o       = 1'b1;
              cmd_o.data   = data_byte_i;
              cmd_o.start  = 1'b1;
              cmd_o.fin    = is_final;
              cmd_o.marker = is_final && au_q;
            end
          end else begin
            idx_d = (idx_q == nfu_pkg::IdxBeyond) ? idx_q : idx_q + 3'd1;
            push_o     = 1'b1;
            cmd_o.data = data_byte_i;
            if (!frag_q) begin
              cmd_o.fin    = is_final;
              cmd_o.marker = is_final && au_q;
            end else begin
              cmd_o.with_fu = (fill_q == '0);
              cmd_o.fu_ind  = (hdr_q & nfu_pkg::NriMask) | nfu_pkg::FuTypeA;
              cmd_o.fu_hdr  = (hdr_q & nfu_pkg::TypeMask)
                            | ((idx_q == nfu_pkg::IdxFirstData) ? nfu_pkg::FuStart : 8'h00)
                            | ((left_w <= fsz_w) ? nfu_pkg::FuEnd : 8'h00);
              cmd_o.fin     = end_frag;
              cmd_o.marker  = end_frag && is_final && au_q;
              fill_d        = end_frag ? '0 : fill_inc;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      hdr_q  <= '0;
      frag_q <= 1'b0;
      fill_q <= '0;
      left_q <= '0;
      drop_q <= 1'b0;
      au_q   <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      hdr_q  <= hdr_d;
      frag_q <= frag_d;
      fill_q <= fill_d;
      left_q <= left_d;
      drop_q <= drop_d;
      au_q   <= au_d;
    end
  end

endmodule

### sv/nfu_queue.sv
// short request queue between front and back end
// depends on nfu_pkg for the request type and depth
module nfu_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  nfu_pkg::cmd_t cmd_i,
  output logic          full_o,
  output logic          valid_o,
  output nfu_pkg::cmd_t head_o,
  input  logic          pop_i
);

  nfu_pkg::cmd_t                   mem_q [nfu_pkg::QDepth];
  logic [nfu_pkg::QPtrW-1:0]       wr_q, rd_q;
  logic [nfu_pkg::QCntW-1:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == nfu_pkg::QCntW'(nfu_pkg::QDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty queue");

endmodule

### sv/nfu_back.sv
// back end: emits each data byte, after fu indicator and fu header if with_fu
// depends on nfu_pkg, drains nfu_queue into a registered output stage
module nfu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  nfu_pkg::cmd_t q_head_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    out_byte_o,
  output logic          packet_start_o,
  output logic          packet_end_o,
  output logic          marker_o,
  output logic          last_o
);

  localparam logic [1:0] PhLead  = 2'd0;
  localparam logic [1:0] PhFuHdr = 2'd1;
  localparam logic [1:0] PhData  = 2'd2;

  logic [1:0] ph_q, ph_d;
  logic       vld_q, vld_d;
  logic [7:0] byte_q, byte_d;
  logic       start_q, start_d, end_q, end_d, mark_q, mark_d, last_q, last_d;
  logic       emit;

  assign emit = q_valid_i && (!vld_q || !out_stall_i);

  always_comb begin
    ph_d    = ph_q;
    vld_d   = vld_q && out_stall_i;
    byte_d  = byte_q;
    start_d = start_q;
    end_d   = end_q;
    mark_d  = mark_q;
    last_d  = last_q;
    q_pop_o = 1'b0;
    if (emit) begin
      vld_d = 1'b1;
      if (q_head_i.with_fu && (ph_q == PhLead)) begin
        byte_d  = q_head_i.fu_ind;
        start_d = 1'b1;
        end_d   = 1'b0;
        mark_d  = 1'b0;
        last_d  = 1'b0;
        ph_d    = PhFuHdr;
      end else if (q_head_i.with_fu && (ph_q == PhFuHdr)) begin
        byte_d  = q_head_i.fu_hdr;
        start_d = 1'b0;
        end_d   = 1'b0;
        mark_d  = 1'b0;
        last_d  = 1'b0;
        ph_d    = PhData;
      end else begin
        byte_d  = q_head_i.data;
        start_d = q_head_i.start;
        end_d   = q_head_i.fin;
        mark_d  = q_head_i.marker;
        last_d  = 1'b1;
        ph_d    = PhLead;
        q_pop_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PhLead;
      vld_q <= 1'b0;
    end else begin
      ph_q  <= ph_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    start_q <= start_d;
    end_q   <= end_d;
    mark_q  <= mark_d;
    last_q  <= last_d;
  end

  assign out_valid_o    = vld_q;
  assign out_byte_o     = byte_q;
  assign packet_start_o = start_q;
  assign packet_end_o   = end_q;
  assign marker_o       = mark_q;
  assign last_o         = last_q;

  a_phase_needs_fu: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q != PhLead) |-> (q_valid_i && q_head_i.with_fu))
    else $error("fu phase without a fragment request");
  a_pop_on_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (vld_q && last_q && (ph_q == PhLead)))
    else $error("request popped before its data byte went out");
  a_marker_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && mark_q) |-> (end_q && last_q))
    else $error("marker away from packet end");

endmodule

### sv/h264_nal_fu_a_fragmenter.sv
// top level of the h.264 nal unit fu-a fragmenter
// depends on nfu_pkg, nfu_front, nfu_queue and nfu_back
//
// usage: nal unit bytes, led by a 3-byte start code, enter on the input
// channel (in_valid_i / in_stall_o) one per cycle unless in_stall_o is high;
// first_byte_i marks the first start-code byte and carries nal_length_i and
// access_unit_end_i. payload bytes leave on the output channel (out_valid_o /
// out_stall_i) with packet_start_o, packet_end_o, marker_o and last_o flags.
// max_payload is written over cfg_valid_i / cfg_ready_o / cfg_data_i; ready
// is always high, writes belong to idle periods.
// an accepted byte's result is registered in the request queue and then in
// the output register; the first byte of a fragment follows its fu
// indicator and fu header. the output carries one byte per cycle while
// out_stall_i is low; each fragment adds output slots for its fu indicator
// and fu header, which the 4-entry request queue turns into input stall
// once it has filled.
// reset clears all unit tracking, empties the queue and loads max_payload
// with 1400. when the receiver stalls, the output register holds and the
// queue fills, after which in_stall_o rises.
module h264_nal_fu_a_fragmenter #(
  parameter int LENGTH_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic [15:0] nal_length_i,
  input  logic        access_unit_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        packet_start_o,
  output logic        packet_end_o,
  output logic        marker_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic [15:0]   max_payload_q;
  logic          q_full, q_valid, q_pop, push, take;
  nfu_pkg::cmd_t cmd, head;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;
  assign take        = in_valid_i && !q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= nfu_pkg::MaxPayloadReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_payload_q <= cfg_data_i;
    end
  end

  nfu_front #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .take_i           (take),
    .data_byte_i      (data_byte_i),
    .first_byte_i     (first_byte_i),
    .nal_length_i     (nal_length_i),
    .access_unit_end_i(access_unit_end_i),
    .max_payload_i    (max_payload_q),
    .push_o           (push),
    .cmd_o            (cmd)
  );

  nfu_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd),
    .full_o (q_full),
    .valid_o(q_valid),
    .head_o (head),
    .pop_i  (q_pop)
  );

  nfu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_head_i      (head),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .packet_start_o(packet_start_o),
    .packet_end_o  (packet_end_o),
    .marker_o      (marker_o),
    .last_o        (last_o)
  );

endmodule
